@@ rtl/tbfe_pkg.sv @@
// shared types, constants and helpers of the tcp burst feature extractor
package tbfe_pkg;

    localparam int BURST_SLOTS  = 16;
    localparam int RECORD_LIMIT = 1024;

    localparam int SLOT_W = (BURST_SLOTS > 1) ? $clog2(BURST_SLOTS) : 1;
    localparam int REC_W  = $clog2(RECORD_LIMIT + 1);

    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [19:0] USEC_MAX     = 20'd999999;
    localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
    localparam logic [15:0] BURST_MAX    = 16'hFFFF;

    // round up to 600: floor((v + 599) / 600), with 600 = 8 * 75 and the
    // division by 75 done as a multiply by a rounded-up reciprocal
    localparam int          ROUND_UNIT  = 600;
    localparam int          ROUND_SHIFT = 3;
    localparam int          ROUND_Y_W   = 30;
    localparam int          RECIP_SHIFT = 37;
    localparam logic [30:0] RECIP_MULT  = 31'd1832519380;
    localparam int          ROUND_Q_W   = 23;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic CFG_CLIENT_ADDR = 1'b0;
    localparam logic CFG_SERVER_ADDR = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        syn_flag;
        logic [15:0] total_length;
        logic [31:0] stamp_sec;
        logic [19:0] stamp_usec;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  burst_index;
        logic [31:0] burst_bytes_rounded;
        logic [15:0] burst_total;
        logic [31:0] client_bytes;
        logic [31:0] server_bytes;
        logic [31:0] span_sec;
        logic [19:0] span_usec;
        logic [10:0] packet_tally;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       data;
    } sum_wr_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/tbfe_sum_ram.sv @@
// burst sum store: one write port, one registered read port, per-slot valid bits
module tbfe_sum_ram import tbfe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  sum_wr_t           wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0]            mem [BURST_SLOTS];
    logic [BURST_SLOTS-1:0] vld_reg;
    logic [31:0]            rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // never-written slots read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 32'd0;

endmodule

@@ rtl/tcp_burst_feature_extractor.sv @@
// top level: tcp connection filter, burst byte sums and report sequencer
//
// input channel s_valid/s_ready/s_data carries one item per handshake: either
// a parsed packet header (cmd = packet) or a report request (cmd = report).
// packets between the two configured endpoints update the time window; those
// without syn also update the direction and burst state, the per-direction
// byte totals and the packet tally. headers stream at one per cycle while no
// report run holds s_ready low. the burst slot update is a read-modify-write
// of the sum ram: read on acceptance, add and write back in the next cycle,
// with a forward path when the next packet hits the same slot.
// a report request produces BURST_SLOTS items on m_valid/m_ready/m_data, one
// per slot, last set on the final one. each item passes in order through the
// ram read, load, reciprocal multiply and multiply-and-saturate states, and
// the next slot starts only once the item is emitted; s_ready stays low for
// the whole run. a stalled receiver holds the result in the output register
// and the report sequencer waits; packets may be accepted again once the run
// is done.
// reset (aresetn, synchronous, active low) clears all counters, the window,
// the endpoint registers and the slot valid bits; no clearing pass is needed.
// cfg_we/cfg_index/cfg_wdata writes an endpoint address, meant while idle.
module tcp_burst_feature_extractor import tbfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // endpoint configuration
    logic [31:0] client_addr_reg;
    logic [31:0] server_addr_reg;

    // connection state
    logic [15:0]      burst_counter_reg;
    logic             cur_dir_reg;
    logic             dir_known_reg;
    logic             time_seen_reg;
    logic [31:0]      earliest_sec_reg;
    logic [19:0]      earliest_usec_reg;
    logic [31:0]      latest_sec_reg;
    logic [19:0]      latest_usec_reg;
    logic [31:0]      client_total_reg;
    logic [31:0]      server_total_reg;
    logic [REC_W-1:0] record_counter_reg;

    // slot update pipeline and forward path
    logic              p1_valid_reg;
    logic [SLOT_W-1:0] p1_addr_reg;
    logic [15:0]       p1_len_reg;
    logic              fwd_valid_reg;
    logic [SLOT_W-1:0] fwd_addr_reg;
    logic [31:0]       fwd_data_reg;

    // report sequencer
    state_t               state_reg;
    logic [SLOT_W-1:0]    rpt_idx_reg;
    logic [ROUND_Y_W-1:0] round_y_reg;
    logic [ROUND_Q_W-1:0] round_q_reg;
    logic [31:0]          span_sec_reg;
    logic [19:0]          span_usec_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic              in_acc;
    logic              rpt_acc;
    logic              kept;
    logic              byte_pkt;
    logic              src_cli;
    logic              src_srv;
    logic              dst_ok;
    logic              pkt_dir;
    logic [19:0]       usec_clamped;
    logic              is_earlier;
    logic              is_later;
    logic [15:0]       burst_counter_next;
    logic              slot_hit;
    logic [SLOT_W-1:0] slot_addr;
    logic [31:0]       ram_rd_data;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic [31:0]       slot_operand;
    sum_wr_t           ram_wr;
    logic              span_borrow;
    logic [20:0]       span_usec_wide;
    logic [32:0]       round_x;
    logic [60:0]       round_prod;
    logic [32:0]       rounded_wide;
    logic [31:0]       rounded_sat;
    logic              out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_acc  = s_valid && s_ready;
    assign rpt_acc = in_acc && (s_data.cmd == CMD_REPORT);

    // connection filter: both ends must be one of the two endpoints
    assign src_cli = (s_data.src_addr == client_addr_reg);
    assign src_srv = (s_data.src_addr == server_addr_reg);
    assign dst_ok  = (s_data.dst_addr == client_addr_reg) ||
                     (s_data.dst_addr == server_addr_reg);
    assign kept    = in_acc && (s_data.cmd == CMD_PACKET) &&
                     (s_data.protocol == PROTO_TCP) && (src_cli || src_srv) && dst_ok;
    assign byte_pkt = kept && !s_data.syn_flag;
    assign pkt_dir  = !src_cli;

    assign usec_clamped = (s_data.stamp_usec > USEC_MAX) ? USEC_MAX : s_data.stamp_usec;
    assign is_earlier = (s_data.stamp_sec < earliest_sec_reg) ||
                        ((s_data.stamp_sec == earliest_sec_reg) &&
                         (usec_clamped < earliest_usec_reg));
    assign is_later   = (latest_sec_reg < s_data.stamp_sec) ||
                        ((latest_sec_reg == s_data.stamp_sec) &&
                         (latest_usec_reg < usec_clamped));

    // a direction change opens a new burst, counter saturates
    always_comb begin
        burst_counter_next = burst_counter_reg;
        if (dir_known_reg && (pkt_dir != cur_dir_reg) && (burst_counter_reg != BURST_MAX)) begin
            burst_counter_next = burst_counter_reg + 16'd1;
        end
    end

    assign slot_hit  = (burst_counter_next < 16'(BURST_SLOTS));
    assign slot_addr = burst_counter_next[SLOT_W-1:0];

    assign ram_rd_addr = (state_reg == ST_READ) ? rpt_idx_reg : slot_addr;

    // read data is stale when the previous cycle wrote the same slot
    assign slot_operand = (fwd_valid_reg && (fwd_addr_reg == p1_addr_reg)) ?
                          fwd_data_reg : ram_rd_data;

    assign ram_wr.en   = p1_valid_reg;
    assign ram_wr.addr = p1_addr_reg;
    assign ram_wr.data = sat_add32(slot_operand, {16'd0, p1_len_reg});

    tbfe_sum_ram u_sum_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // span of the time window, one second borrowed when usec wraps
    assign span_borrow    = (latest_usec_reg < earliest_usec_reg);
    assign span_usec_wide = span_borrow ?
                            ({1'b0, latest_usec_reg} + USEC_PER_SEC - {1'b0, earliest_usec_reg}) :
                            ({1'b0, latest_usec_reg} - {1'b0, earliest_usec_reg});

    // rounding datapath, one step in each of the load, div and emit states
    assign round_x      = {1'b0, ram_rd_data} + 33'(ROUND_UNIT - 1);
    assign round_prod   = 61'(round_y_reg) * 61'(RECIP_MULT);
    assign rounded_wide = 33'(round_q_reg) * 33'(ROUND_UNIT);
    assign rounded_sat  = rounded_wide[32] ? 32'hFFFF_FFFF : rounded_wide[31:0];

    assign out_free = !m_valid_reg || m_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_addr_reg <= '0;
            server_addr_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CLIENT_ADDR: client_addr_reg <= cfg_wdata;
                CFG_SERVER_ADDR: server_addr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-packet state: time window, direction, totals, tally
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_counter_reg  <= '0;
            cur_dir_reg        <= 1'b0;
            dir_known_reg      <= 1'b0;
            time_seen_reg      <= 1'b0;
            earliest_sec_reg   <= '0;
            earliest_usec_reg  <= '0;
            latest_sec_reg     <= '0;
            latest_usec_reg    <= '0;
            client_total_reg   <= '0;
            server_total_reg   <= '0;
            record_counter_reg <= '0;
        end else begin
            if (kept) begin
                time_seen_reg <= 1'b1;
                if (!time_seen_reg || is_earlier) begin
                    earliest_sec_reg  <= s_data.stamp_sec;
                    earliest_usec_reg <= usec_clamped;
                end
                if (!time_seen_reg || is_later) begin
                    latest_sec_reg  <= s_data.stamp_sec;
                    latest_usec_reg <= usec_clamped;
                end
            end
            if (byte_pkt) begin
                dir_known_reg     <= 1'b1;
                cur_dir_reg       <= pkt_dir;
                burst_counter_reg <= burst_counter_next;
                if (!pkt_dir) begin
                    client_total_reg <= sat_add32(client_total_reg, {16'd0, s_data.total_length});
                end else begin
                    server_total_reg <= sat_add32(server_total_reg, {16'd0, s_data.total_length});
                end
                if (record_counter_reg < REC_W'(RECORD_LIMIT)) begin
                    record_counter_reg <= record_counter_reg + REC_W'(1);
                end
            end
        end
    end

    // slot read-modify-write pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= byte_pkt && slot_hit;
            fwd_valid_reg <= p1_valid_reg;
        end
        p1_addr_reg  <= slot_addr;
        p1_len_reg   <= s_data.total_length;
        fwd_addr_reg <= p1_addr_reg;
        fwd_data_reg <= ram_wr.data;
    end

    // report sequencer with its output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rpt_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // while emitting, the emit branch alone drives the valid flag
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    rpt_idx_reg <= '0;
                    if (rpt_acc) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    round_y_reg <= ROUND_Y_W'(round_x >> ROUND_SHIFT);
                    if (time_seen_reg) begin
                        span_sec_reg  <= latest_sec_reg - earliest_sec_reg -
                                         {31'd0, span_borrow};
                        span_usec_reg <= span_usec_wide[19:0];
                    end else begin
                        span_sec_reg  <= '0;
                        span_usec_reg <= '0;
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    round_q_reg <= ROUND_Q_W'(round_prod >> RECIP_SHIFT);
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                    <= 1'b1;
                        m_data_reg.burst_index         <= 4'(rpt_idx_reg);
                        m_data_reg.burst_bytes_rounded <= rounded_sat;
                        m_data_reg.burst_total         <= burst_counter_reg;
                        m_data_reg.client_bytes        <= client_total_reg;
                        m_data_reg.server_bytes        <= server_total_reg;
                        m_data_reg.span_sec            <= span_sec_reg;
                        m_data_reg.span_usec           <= span_usec_reg;
                        m_data_reg.packet_tally        <= 11'(record_counter_reg);
                        m_data_reg.last                <= (rpt_idx_reg == SLOT_W'(BURST_SLOTS - 1));
                        if (rpt_idx_reg == SLOT_W'(BURST_SLOTS - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rpt_idx_reg <= rpt_idx_reg + SLOT_W'(1);
                            state_reg   <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
